// ----- hdl/bsc_pkg.sv -----
// Shared constants, types and helpers for the barometric compensation pipeline
`default_nettype none
package bsc_pkg;

   localparam int unsigned RAW_W     = 20;
   localparam int unsigned CAL_W     = 48;
   localparam int unsigned COEF_W    = 16;
   localparam int unsigned TEMP_W    = 26;
   localparam int unsigned PRESS_W   = 32;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned WORD_W    = 64;
   localparam int unsigned DEN_W     = 31;

   localparam int unsigned HEAD_STAGES = 12;
   localparam int unsigned TAIL_STAGES = 6;
   localparam int unsigned PIPE_DEPTH  = HEAD_STAGES + WORD_W + TAIL_STAGES;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_CAL = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_A  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_B  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_C  = 8'd3;

   localparam int unsigned FINE_OFFSET = 128000;
   localparam int unsigned PRESS_BASE  = 1048576;
   localparam int unsigned TEMP_ROUND  = 128;
   localparam logic [11:0] NUM_SCALE   = 12'd3125;
   localparam logic [WORD_W-1:0] P1_BIAS = 64'h0000_8000_0000_0000;

   localparam int unsigned SH_T2   = 11;
   localparam int unsigned SH_DSQ  = 12;
   localparam int unsigned SH_T3   = 14;
   localparam int unsigned SH_TEMP = 8;
   localparam int unsigned SH_P5   = 17;
   localparam int unsigned SH_P4   = 35;
   localparam int unsigned SH_A3   = 8;
   localparam int unsigned SH_P2   = 12;
   localparam int unsigned SH_DEN  = 33;
   localparam int unsigned SH_NUM  = 31;
   localparam int unsigned SH_Q    = 13;
   localparam int unsigned SH_P9   = 25;
   localparam int unsigned SH_P8   = 19;
   localparam int unsigned SH_P    = 8;
   localparam int unsigned SH_P7   = 4;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic                     dz;
      logic                     neg;
   } div_tag_type;

   function automatic logic [WORD_W-1:0] asr64(input logic [WORD_W-1:0] x,
                                               input int unsigned s);
      logic signed [WORD_W-1:0] xs;
      xs = x;
      return xs >>> s;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/bsc_if.sv -----
// Channel interfaces: sample request, result response and register write
`default_nettype none
interface bsc_req_if;
   logic                        valid;
   logic                        ready;
   logic [bsc_pkg::RAW_W-1:0]   raw_temp;
   logic [bsc_pkg::RAW_W-1:0]   raw_press;
   modport source (output valid, raw_temp, raw_press, input ready);
   modport sink (input valid, raw_temp, raw_press, output ready);
endinterface

interface bsc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [bsc_pkg::TEMP_W-1:0] temp_centi;
   logic [bsc_pkg::PRESS_W-1:0]      press_q24_8;
   logic                             div_zero;
   modport source (output valid, temp_centi, press_q24_8, div_zero, input ready);
   modport sink (input valid, temp_centi, press_q24_8, div_zero, output ready);
endinterface

interface bsc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bsc_pkg::CSR_IDX_W-1:0]   index;
   logic [bsc_pkg::CAL_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/bsc_mul.sv -----
// Two-stage 64x64 multiplier keeping the low 64 product bits
`default_nettype none
module bsc_mul (
   input  logic                       clock,
   input  logic                       en,
   input  logic [bsc_pkg::WORD_W-1:0] a,
   input  logic [bsc_pkg::WORD_W-1:0] b,
   output logic [bsc_pkg::WORD_W-1:0] p
);
   localparam int unsigned W    = bsc_pkg::WORD_W;
   localparam int unsigned HALF = W / 2;

   logic [W-1:0]    ll_in, ll_ff;
   logic [HALF-1:0] lh_in, lh_ff;
   logic [HALF-1:0] hl_in, hl_ff;
   logic [W-1:0]    p_in, p_ff;

   assign ll_in = a[HALF-1:0] * b[HALF-1:0];
   assign lh_in = a[HALF-1:0] * b[W-1:HALF];
   assign hl_in = a[W-1:HALF] * b[HALF-1:0];
   assign p_in  = ll_ff + {lh_ff + hl_ff, {HALF{1'b0}}};

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;
endmodule
`default_nettype wire

// ----- hdl/bsc_div_cell.sv -----
// One restoring-division cell: produces one quotient bit per stage
`default_nettype none
module bsc_div_cell (
   input  logic                       clock,
   input  logic                       en,
   input  logic [bsc_pkg::DEN_W-1:0]  rem_prev,
   input  logic [bsc_pkg::DEN_W-1:0]  den_prev,
   input  logic [bsc_pkg::WORD_W-1:0] work_prev,
   input  bsc_pkg::div_tag_type       tag_prev,
   output logic [bsc_pkg::DEN_W-1:0]  rem_next,
   output logic [bsc_pkg::DEN_W-1:0]  den_next,
   output logic [bsc_pkg::WORD_W-1:0] work_next,
   output bsc_pkg::div_tag_type       tag_next
);
   localparam int unsigned DW = bsc_pkg::DEN_W;
   localparam int unsigned W  = bsc_pkg::WORD_W;

   logic [DW:0]          trial;
   logic [DW+1:0]        diff;
   logic                 ge;
   logic [DW-1:0]        rem_in, rem_ff;
   logic [DW-1:0]        den_ff;
   logic [W-1:0]         work_in, work_ff;
   bsc_pkg::div_tag_type tag_ff;

   assign trial   = {rem_prev, work_prev[W-1]};
   assign diff    = {1'b0, trial} - {2'b00, den_prev};
   assign ge      = ~diff[DW+1];
   assign rem_in  = ge ? diff[DW-1:0] : trial[DW-1:0];
   assign work_in = {work_prev[W-2:0], ge};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         den_ff  <= den_prev;
         work_ff <= work_in;
         tag_ff  <= tag_prev;
      end
   end

   assign rem_next  = rem_ff;
   assign den_next  = den_ff;
   assign work_next = work_ff;
   assign tag_next  = tag_ff;
endmodule
`default_nettype wire

// ----- hdl/bsc_div.sv -----
// Unsigned 64-by-31 bit divider built as a chain of one-bit cells
`default_nettype none
module bsc_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [bsc_pkg::WORD_W-1:0] num,
   input  logic [bsc_pkg::DEN_W-1:0]  den,
   input  bsc_pkg::div_tag_type       tag,
   output logic [bsc_pkg::WORD_W-1:0] quo,
   output bsc_pkg::div_tag_type       quo_tag
);
   localparam int unsigned STEPS = bsc_pkg::WORD_W;
   localparam int unsigned DW    = bsc_pkg::DEN_W;

   logic [DW-1:0]        rem_c  [0:STEPS];
   logic [DW-1:0]        den_c  [0:STEPS];
   logic [STEPS-1:0]     work_c [0:STEPS];
   bsc_pkg::div_tag_type tag_c  [0:STEPS];

   assign rem_c[0]  = '0;
   assign den_c[0]  = den;
   assign work_c[0] = num;
   assign tag_c[0]  = tag;

   for (genvar k = 0; k < STEPS; k++) begin : g_cell
      bsc_div_cell u_cell (
         .clock     (clock),
         .en        (en),
         .rem_prev  (rem_c[k]),
         .den_prev  (den_c[k]),
         .work_prev (work_c[k]),
         .tag_prev  (tag_c[k]),
         .rem_next  (rem_c[k+1]),
         .den_next  (den_c[k+1]),
         .work_next (work_c[k+1]),
         .tag_next  (tag_c[k+1])
      );
   end

   assign quo     = work_c[STEPS];
   assign quo_tag = tag_c[STEPS];
endmodule
`default_nettype wire

// ----- hdl/baro_sensor_compensation.sv -----
// Barometric sensor compensation top level: pipelined temperature and pressure path.
// Request to response path: 12 head stages, 64 divider cells, 6 tail stages and the
// output register; the first head stage loads at the accept edge.
// Throughput: one transaction per cycle; a skid register takes one more result while a
// response waits, then the pipeline and the request input stall until it drains.
// Reset clears the calibration registers to zero and empties the pipeline and outputs.
`default_nettype none
module baro_sensor_compensation (
   input  logic       clock,
   input  logic       reset,
   bsc_req_if.sink    req_chan,
   bsc_rsp_if.source  rsp_chan,
   bsc_csr_if.sink    csr_chan
);
   localparam int unsigned W     = bsc_pkg::WORD_W;
   localparam int unsigned CW    = bsc_pkg::CAL_W;
   localparam int unsigned RW    = bsc_pkg::RAW_W;
   localparam int unsigned TW    = bsc_pkg::TEMP_W;
   localparam int unsigned PW    = bsc_pkg::PRESS_W;
   localparam int unsigned DW    = bsc_pkg::DEN_W;
   localparam int unsigned DEPTH = bsc_pkg::PIPE_DEPTH;

   typedef struct packed {
      logic signed [TW-1:0] temp_centi;
      logic [PW-1:0]        press;
      logic                 div_zero;
   } rsp_data_type;

   // calibration registers
   logic [CW-1:0] temp_cal_ff, press_a_ff, press_b_ff, press_c_ff;

   assign csr_chan.ready = ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff <= '0;
         press_a_ff  <= '0;
         press_b_ff  <= '0;
         press_c_ff  <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            bsc_pkg::CSR_TEMP_CAL: temp_cal_ff <= csr_chan.data;
            bsc_pkg::CSR_PRESS_A:  press_a_ff  <= csr_chan.data;
            bsc_pkg::CSR_PRESS_B:  press_b_ff  <= csr_chan.data;
            bsc_pkg::CSR_PRESS_C:  press_c_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = temp_cal_ff[15:0];
   assign t2 = temp_cal_ff[31:16];
   assign t3 = temp_cal_ff[47:32];
   assign p1 = press_a_ff[15:0];
   assign p2 = press_a_ff[31:16];
   assign p3 = press_a_ff[47:32];
   assign p4 = press_b_ff[15:0];
   assign p5 = press_b_ff[31:16];
   assign p6 = press_b_ff[47:32];
   assign p7 = press_c_ff[15:0];
   assign p8 = press_c_ff[31:16];
   assign p9 = press_c_ff[47:32];

   // pipeline control
   logic             adv;
   logic [DEPTH-1:0] vld_ff;
   logic             skid_vld_ff, out_vld_ff;

   assign adv            = ~skid_vld_ff;
   assign req_chan.ready = adv & ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_chan.valid};
      end
   end

   // head stage signals
   logic signed [18:0] dt_in, dt0_ff;
   logic signed [17:0] dl_in, dl0_ff;
   logic [RW-1:0]      adcp0_ff, adcp1_ff, adcp2_ff, adcp3_ff, adcp4_ff, adcp5_ff;
   logic [RW-1:0]      adcp6_ff, adcp7_ff;
   logic signed [34:0] tmul;
   logic signed [23:0] ta1_in, ta1_ff, ta2_ff;
   logic signed [35:0] dsq;
   logic [31:0]        dsq1_ff;
   logic signed [36:0] tb2_in, tb2_ff;
   logic signed [22:0] tbs;
   logic signed [TW-1:0] fine3_in, fine3_ff;
   logic signed [29:0] f30, t30;
   logic signed [TW-1:0] temp4_in, temp4_ff, temp5_ff, temp6_ff, temp7_ff, temp8_ff;
   logic signed [TW-1:0] temp9_ff, temp10_ff;
   logic signed [TW-1:0] pa4_in, pa4_ff;
   logic signed [51:0] aa;
   logic signed [47:0] aa5_ff;
   logic signed [41:0] ap5_in, ap5_5_ff, ap5_6_ff;
   logic signed [41:0] ap2_in, ap2_5_ff, ap2_6_ff;
   logic signed [63:0] b1_in, a1_in;
   logic [W-1:0]       b1_ff, a1_ff;
   logic [W-1:0]       ap5_w, ap2_w, p4_w, p7_w, p8_w, p9_w;
   logic [W-1:0]       b7_in, b7_ff, ax7_in, ax7_ff;
   logic [47:0]        lo8_in, lo8_ff;
   logic [31:0]        hi8_in, hi8_ff;
   logic [20:0]        pp;
   logic [W-1:0]       num8_in, num8_ff;
   logic [W-1:0]       prod9;
   logic [DW-1:0]      den9_in, den9_ff, den10_ff;
   logic [43:0]        nlo9_in, nlo9_ff;
   logic [31:0]        nhi9_in, nhi9_ff;
   logic [W-1:0]       num10_in, num10_ff;
   logic               na, nb;
   logic [W-1:0]       magn11_in, magn11_ff;
   logic [DW-1:0]      magd11_in, magd11_ff;
   bsc_pkg::div_tag_type tag11_in, tag11_ff;

   assign dt_in = $signed({2'b00, req_chan.raw_temp[RW-1:3]}) - $signed({2'b00, t1, 1'b0});
   assign dl_in = $signed({2'b00, req_chan.raw_temp[RW-1:4]}) - $signed({2'b00, t1});

   assign tmul   = dt0_ff * t2;
   assign ta1_in = 24'(tmul >>> bsc_pkg::SH_T2);
   assign dsq    = dl0_ff * dl0_ff;

   assign tb2_in = $signed({1'b0, dsq1_ff[31:bsc_pkg::SH_DSQ]}) * t3;

   assign tbs      = 23'(tb2_ff >>> bsc_pkg::SH_T3);
   assign fine3_in = {{2{ta2_ff[23]}}, ta2_ff} + {{3{tbs[22]}}, tbs};

   assign f30      = {{4{fine3_ff[TW-1]}}, fine3_ff};
   assign t30      = (f30 <<< 2) + f30 + 30'(bsc_pkg::TEMP_ROUND);
   assign temp4_in = 26'(t30 >>> bsc_pkg::SH_TEMP);
   assign pa4_in   = fine3_ff - 26'(bsc_pkg::FINE_OFFSET);

   assign aa     = pa4_ff * pa4_ff;
   assign ap5_in = pa4_ff * p5;
   assign ap2_in = pa4_ff * p2;

   assign b1_in = aa5_ff * p6;
   assign a1_in = aa5_ff * p3;

   assign ap5_w  = {{22{ap5_6_ff[41]}}, ap5_6_ff};
   assign ap2_w  = {{22{ap2_6_ff[41]}}, ap2_6_ff};
   assign p4_w   = {{48{p4[15]}}, p4};
   assign p7_w   = {{48{p7[15]}}, p7};
   assign p8_w   = {{48{p8[15]}}, p8};
   assign p9_w   = {{48{p9[15]}}, p9};
   assign b7_in  = b1_ff + (ap5_w << bsc_pkg::SH_P5) + (p4_w << bsc_pkg::SH_P4);
   assign ax7_in = bsc_pkg::asr64(a1_ff, bsc_pkg::SH_A3) + (ap2_w << bsc_pkg::SH_P2)
                   + bsc_pkg::P1_BIAS;

   assign lo8_in  = ax7_ff[31:0] * p1;
   assign hi8_in  = ax7_ff[W-1:32] * p1;
   assign pp      = 21'(bsc_pkg::PRESS_BASE) - {1'b0, adcp7_ff};
   assign num8_in = ({{(W-21){1'b0}}, pp} << bsc_pkg::SH_NUM) - b7_ff;

   assign prod9   = {16'b0, lo8_ff} + {hi8_ff, 32'b0};
   assign den9_in = DW'(prod9 >> bsc_pkg::SH_DEN);
   assign nlo9_in = num8_ff[31:0] * bsc_pkg::NUM_SCALE;
   assign nhi9_in = num8_ff[W-1:32] * bsc_pkg::NUM_SCALE;

   assign num10_in = {20'b0, nlo9_ff} + {nhi9_ff, 32'b0};

   assign na        = num10_ff[W-1];
   assign nb        = den10_ff[DW-1];
   assign magn11_in = na ? ({W{1'b0}} - num10_ff) : num10_ff;
   assign magd11_in = nb ? ({DW{1'b0}} - den10_ff) : den10_ff;
   assign tag11_in  = '{temp: temp10_ff, dz: (den10_ff == '0), neg: na ^ nb};

   always_ff @(posedge clock) begin
      if (adv) begin
         dt0_ff    <= dt_in;
         dl0_ff    <= dl_in;
         adcp0_ff  <= req_chan.raw_press;
         ta1_ff    <= ta1_in;
         dsq1_ff   <= dsq[31:0];
         adcp1_ff  <= adcp0_ff;
         ta2_ff    <= ta1_ff;
         tb2_ff    <= tb2_in;
         adcp2_ff  <= adcp1_ff;
         fine3_ff  <= fine3_in;
         adcp3_ff  <= adcp2_ff;
         temp4_ff  <= temp4_in;
         pa4_ff    <= pa4_in;
         adcp4_ff  <= adcp3_ff;
         aa5_ff    <= aa[47:0];
         ap5_5_ff  <= ap5_in;
         ap2_5_ff  <= ap2_in;
         temp5_ff  <= temp4_ff;
         adcp5_ff  <= adcp4_ff;
         b1_ff     <= b1_in;
         a1_ff     <= a1_in;
         ap5_6_ff  <= ap5_5_ff;
         ap2_6_ff  <= ap2_5_ff;
         temp6_ff  <= temp5_ff;
         adcp6_ff  <= adcp5_ff;
         b7_ff     <= b7_in;
         ax7_ff    <= ax7_in;
         temp7_ff  <= temp6_ff;
         adcp7_ff  <= adcp6_ff;
         lo8_ff    <= lo8_in;
         hi8_ff    <= hi8_in;
         num8_ff   <= num8_in;
         temp8_ff  <= temp7_ff;
         den9_ff   <= den9_in;
         nlo9_ff   <= nlo9_in;
         nhi9_ff   <= nhi9_in;
         temp9_ff  <= temp8_ff;
         num10_ff  <= num10_in;
         den10_ff  <= den9_ff;
         temp10_ff <= temp9_ff;
         magn11_ff <= magn11_in;
         magd11_ff <= magd11_in;
         tag11_ff  <= tag11_in;
      end
   end

   // divider chain
   logic [W-1:0]         quo;
   bsc_pkg::div_tag_type quo_tag;

   bsc_div u_div (
      .clock   (clock),
      .en      (adv),
      .num     (magn11_ff),
      .den     (magd11_ff),
      .tag     (tag11_ff),
      .quo     (quo),
      .quo_tag (quo_tag)
   );

   // tail stages
   logic [W-1:0]         q0_in, q0_ff, qd1_ff, qd2_ff, qd3_ff, qd4_ff;
   bsc_pkg::div_tag_type tag0_ff, tagd1_ff, tagd2_ff, tagd3_ff, tagd4_ff, tag5_ff;
   logic [W-1:0]         x0, sq, mp8, mp9, mp8d1_ff, mp8d2_ff;
   logic [W-1:0]         s5_in, s5_ff;

   assign q0_in = quo_tag.neg ? ({W{1'b0}} - quo) : quo;
   assign x0    = bsc_pkg::asr64(q0_ff, bsc_pkg::SH_Q);

   bsc_mul u_mul_sq (.clock(clock), .en(adv), .a(x0), .b(x0), .p(sq));
   bsc_mul u_mul_p8 (.clock(clock), .en(adv), .a(q0_ff), .b(p8_w), .p(mp8));
   bsc_mul u_mul_p9 (.clock(clock), .en(adv), .a(sq), .b(p9_w), .p(mp9));

   assign s5_in = qd4_ff + bsc_pkg::asr64(mp9, bsc_pkg::SH_P9)
                  + bsc_pkg::asr64(mp8d2_ff, bsc_pkg::SH_P8);

   always_ff @(posedge clock) begin
      if (adv) begin
         q0_ff    <= q0_in;
         tag0_ff  <= quo_tag;
         qd1_ff   <= q0_ff;
         qd2_ff   <= qd1_ff;
         qd3_ff   <= qd2_ff;
         qd4_ff   <= qd3_ff;
         tagd1_ff <= tag0_ff;
         tagd2_ff <= tagd1_ff;
         tagd3_ff <= tagd2_ff;
         tagd4_ff <= tagd3_ff;
         mp8d1_ff <= mp8;
         mp8d2_ff <= mp8d1_ff;
         s5_ff    <= s5_in;
         tag5_ff  <= tagd4_ff;
      end
   end

   // final scaling and saturation
   logic [W-1:0]  r_fin;
   logic [PW-1:0] press_fin;
   rsp_data_type  new_data, out_ff, skid_ff;
   logic          arr;

   assign r_fin = bsc_pkg::asr64(s5_ff, bsc_pkg::SH_P) + (p7_w << bsc_pkg::SH_P7);

   always_comb begin
      if (tag5_ff.dz || r_fin[W-1]) begin
         press_fin = '0;
      end else if (|r_fin[W-2:PW]) begin
         press_fin = '1;
      end else begin
         press_fin = r_fin[PW-1:0];
      end
   end

   assign new_data = '{temp_centi: tag5_ff.temp, press: press_fin, div_zero: tag5_ff.dz};
   assign arr      = adv & vld_ff[DEPTH-1];

   // output register with skid slot
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_chan.ready) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= arr;
         end
      end else if (arr) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_chan.ready) begin
         if (skid_vld_ff) begin
            out_ff <= skid_ff;
         end else if (arr) begin
            out_ff <= new_data;
         end
      end else if (arr) begin
         skid_ff <= new_data;
      end
   end

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.temp_centi  = out_ff.temp_centi;
   assign rsp_chan.press_q24_8 = out_ff.press;
   assign rsp_chan.div_zero    = out_ff.div_zero;
endmodule
`default_nettype wire
